// ===== src/cffdo_pkg.sv =====
// ============================================================================
// Chunked frame FIFO package
// Shared constants, codes and defaults for the chunked frame FIFO.
// ============================================================================
package cffdo_pkg;

    localparam int MAX_CHUNK_FRAMES_DEF = 64;
    localparam int MAX_CHUNKS_DEF       = 16;
    localparam int FRAME_WIDTH_DEF      = 32;

    localparam int LEN_W   = 7;
    localparam int LIM_W   = 5;
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 64;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_SEL = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
    localparam logic [LIM_W-1:0] LIM_RESET = 5'd0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_CHUNK = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    typedef enum logic {
        REG_CHUNK_LENGTH = 1'b0,
        REG_CHUNK_LIMIT  = 1'b1
    } reg_idx_t;

endpackage

// ===== src/cffdo_ram.sv =====
// ============================================================================
// Chunked frame FIFO storage RAM
// Simple dual-port synchronous RAM with a registered read port.
// ============================================================================
module cffdo_ram #(
    parameter int WIDTH = cffdo_pkg::FRAME_WIDTH_DEF,
    parameter int DEPTH = cffdo_pkg::MAX_CHUNKS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/chunked_frame_fifo_drop_oldest_unit.sv =====
// ============================================================================
// Chunked frame FIFO with drop-oldest overflow
// Buffers frames in fixed-length chunks and hands back the oldest chunk on pop.
// ============================================================================
// Words enter on the s_ channel and carry an operation: push a frame, pop the
// oldest chunk, or flush. Results leave on the m_ channel through an output
// register, so a new word is taken in the same cycle as the waiting result
// leaves. A push, an empty pop and a flush each give one result word. A push
// is taken every cycle while the receiver keeps up; its status word shows in
// the cycle after acceptance. A pop streams the oldest chunk one frame per
// cycle from the frame RAM while the receiver keeps up: the pop state is
// entered, each frame RAM read is registered, and each frame then passes to
// the output register. The pop holds the input until its last frame is
// loaded. Opening a chunk beyond the chunk limit drops the oldest chunk and
// flags it on the push status word.
// Reset empties the buffer at once, with no clearing pass, and sets chunk
// length to 64 and chunk limit to 0 (full capacity). The RAM contents stay
// undefined until written. When the receiver stalls, the output register
// holds its word and no further word is taken until it drains.
// The APB port holds chunk_length at 0x0 and chunk_limit at 0x4.
// ============================================================================
module chunked_frame_fifo_drop_oldest_unit #(
    parameter int MAX_CHUNK_FRAMES = cffdo_pkg::MAX_CHUNK_FRAMES_DEF,
    parameter int MAX_CHUNKS       = cffdo_pkg::MAX_CHUNKS_DEF,
    parameter int FRAME_WIDTH      = cffdo_pkg::FRAME_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cffdo_pkg::APB_AW-1:0]        paddr,
    input  logic [cffdo_pkg::APB_DW-1:0]        pwdata,
    output logic [cffdo_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cffdo_pkg::OP_W-1:0]          s_operation,
    input  logic [cffdo_pkg::DATA_W-1:0]        s_frame_data,
    input  logic signed [cffdo_pkg::TIME_W-1:0] s_frame_time,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cffdo_pkg::DATA_W-1:0]        m_out_frame,
    output logic signed [cffdo_pkg::TIME_W-1:0] m_chunk_start_time,
    output logic [cffdo_pkg::KIND_W-1:0]        m_kind,
    output logic                                m_last,
    output logic                                m_ready_res,
    output logic                                m_dropped
);

    localparam int LEN_W = cffdo_pkg::LEN_W;
    localparam int TIME_W = cffdo_pkg::TIME_W;
    localparam int DATA_W = cffdo_pkg::DATA_W;
    localparam int DEPTH = MAX_CHUNKS * MAX_CHUNK_FRAMES;
    localparam int FA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int BUF_W = $clog2(DEPTH + 1);
    localparam int FP_W  = (MAX_CHUNK_FRAMES > 1) ? $clog2(MAX_CHUNK_FRAMES) : 1;
    localparam int CMP_W = (BUF_W > LEN_W) ? BUF_W : LEN_W;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]            len_reg;
    logic [cffdo_pkg::LIM_W-1:0] lim_reg;

    logic [CH_W-1:0]  head_reg, head_next;
    logic [CH_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [FP_W-1:0]  fill_reg, fill_next;

    logic [CH_W-1:0]  slot_reg;
    logic [LEN_W-1:0] n_reg;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] em_reg;
    logic             rd_pend_reg;
    logic             pop_ready_reg;

    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_frame_reg;
    logic signed [TIME_W-1:0] m_time_reg;
    logic [cffdo_pkg::KIND_W-1:0] m_kind_reg;
    logic                     m_last_reg;
    logic                     m_ready_res_reg;
    logic                     m_dropped_reg;

    logic [LEN_W-1:0] eff_len;
    logic [CNT_W-1:0] eff_lim;
    logic             s_fire;
    logic             out_free;
    logic             out_load;
    logic             cfg_we;

    logic             push_drop;
    logic             push_ready;
    logic             pop_empty;
    logic             pop_go;
    logic             pop_ready;
    logic [LEN_W-1:0] pop_n;
    logic             push_go;
    logic             flush_go;

    logic [CH_W-1:0]        tail_prev;
    logic [CH_W-1:0]        tail_inc;
    logic [CH_W-1:0]        head_inc;
    logic [LEN_W-1:0]       fill_plus;
    logic [BUF_W-1:0]       buf_after_drop;
    logic [CNT_W-1:0]       count_after_drop;

    logic                   fw_en;
    logic [FA_W-1:0]        fw_addr;
    logic [FRAME_WIDTH-1:0] fw_data;
    logic                   tw_en;
    logic                   f_issue;
    logic                   f_load;
    logic [FA_W-1:0]        fr_addr;
    logic [FRAME_WIDTH-1:0] fr_data;
    logic [TIME_W-1:0]      tr_data;

    function automatic logic [FA_W-1:0] frame_addr(input logic [CH_W-1:0] chunk,
                                                   input logic [FP_W-1:0] idx);
        frame_addr = FA_W'(chunk) * FA_W'(MAX_CHUNK_FRAMES) + FA_W'(idx);
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= cffdo_pkg::LEN_RESET;
            lim_reg <= cffdo_pkg::LIM_RESET;
        end else if (cfg_we) begin
            unique case (cffdo_pkg::reg_idx_t'(paddr[cffdo_pkg::REG_SEL]))
                cffdo_pkg::REG_CHUNK_LENGTH: len_reg <= pwdata[LEN_W-1:0];
                cffdo_pkg::REG_CHUNK_LIMIT:  lim_reg <= pwdata[cffdo_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cffdo_pkg::reg_idx_t'(paddr[cffdo_pkg::REG_SEL]))
            cffdo_pkg::REG_CHUNK_LENGTH: prdata = cffdo_pkg::APB_DW'(len_reg);
            cffdo_pkg::REG_CHUNK_LIMIT:  prdata = cffdo_pkg::APB_DW'(lim_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        if (len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(len_reg) > MAX_CHUNK_FRAMES) begin
            eff_len = LEN_W'(MAX_CHUNK_FRAMES);
        end else begin
            eff_len = len_reg;
        end
        if (lim_reg == '0 || int'(lim_reg) > MAX_CHUNKS) begin
            eff_lim = CNT_W'(MAX_CHUNKS);
        end else begin
            eff_lim = CNT_W'(lim_reg);
        end
    end

    // Handshake.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign tail_prev = (tail_reg == '0) ? CH_W'(MAX_CHUNKS - 1) : tail_reg - CH_W'(1);
    assign tail_inc  = (tail_reg == CH_W'(MAX_CHUNKS - 1)) ? '0 : tail_reg + CH_W'(1);
    assign head_inc  = (head_reg == CH_W'(MAX_CHUNKS - 1)) ? '0 : head_reg + CH_W'(1);
    assign fill_plus = LEN_W'(fill_reg) + LEN_W'(1);

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        buf_next         = buf_reg;
        fill_next        = fill_reg;
        push_go          = 1'b0;
        push_drop        = 1'b0;
        pop_empty        = 1'b0;
        pop_go           = 1'b0;
        flush_go         = 1'b0;
        pop_n            = '0;
        fw_en            = 1'b0;
        tw_en            = 1'b0;
        fw_addr          = frame_addr(tail_reg, '0);
        buf_after_drop   = buf_reg;
        count_after_drop = count_reg;
        if (s_fire) begin
            unique case (s_operation)
                cffdo_pkg::OP_PUSH: begin
                    push_go = 1'b1;
                    fw_en   = 1'b1;
                    if (count_reg != '0 && fill_reg != '0 && LEN_W'(fill_reg) < eff_len) begin
                        fw_addr  = frame_addr(tail_prev, fill_reg);
                        buf_next = buf_reg + BUF_W'(1);
                        if (fill_plus >= eff_len) begin
                            fill_next = '0;
                        end else begin
                            fill_next = fill_plus[FP_W-1:0];
                        end
                    end else begin
                        if (count_reg >= eff_lim) begin
                            push_drop        = 1'b1;
                            head_next        = head_inc;
                            count_after_drop = count_reg - CNT_W'(1);
                            if (CMP_W'(buf_reg) > CMP_W'(eff_len)) begin
                                buf_after_drop = BUF_W'(CMP_W'(buf_reg) - CMP_W'(eff_len));
                            end else begin
                                buf_after_drop = '0;
                            end
                        end
                        tw_en      = 1'b1;
                        tail_next  = tail_inc;
                        count_next = count_after_drop + CNT_W'(1);
                        buf_next   = buf_after_drop + BUF_W'(1);
                        fill_next  = (eff_len > LEN_W'(1)) ? FP_W'(1) : '0;
                    end
                end
                cffdo_pkg::OP_POP: begin
                    if (buf_reg == '0 || count_reg == '0) begin
                        pop_empty = 1'b1;
                    end else begin
                        pop_go = 1'b1;
                        if (CMP_W'(buf_reg) < CMP_W'(eff_len)) begin
                            pop_n = LEN_W'(buf_reg);
                        end else begin
                            pop_n = eff_len;
                        end
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            buf_next  = '0;
                            fill_next = '0;
                        end else begin
                            buf_next = BUF_W'(CMP_W'(buf_reg) - CMP_W'(pop_n));
                        end
                    end
                end
                cffdo_pkg::OP_FLUSH: begin
                    flush_go   = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    buf_next   = '0;
                    fill_next  = '0;
                end
                default: ;
            endcase
        end
    end

    assign push_ready = CMP_W'(buf_next) >= CMP_W'(eff_len);
    assign pop_ready  = push_ready;

    // Chunk streaming: one frame read per cycle while the output drains, one read ahead of the output.
    assign f_load  = (state_reg == ST_POP) && rd_pend_reg && out_free;
    assign f_issue = (state_reg == ST_POP) && (rd_idx_reg != n_reg)
                     && (!rd_pend_reg || f_load);
    assign fr_addr = frame_addr(slot_reg, rd_idx_reg[FP_W-1:0]);
    assign fw_data = FRAME_WIDTH'(64'(s_frame_data));

    assign out_load = push_go || pop_empty || flush_go || f_load;

    cffdo_ram #(
        .WIDTH (FRAME_WIDTH),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (fw_en),
        .waddr (fw_addr),
        .wdata (fw_data),
        .re    (f_issue),
        .raddr (fr_addr),
        .rdata (fr_data)
    );

    cffdo_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_CHUNKS)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (tw_en),
        .waddr (tail_reg),
        .wdata (s_frame_time),
        .re    (pop_go),
        .raddr (head_reg),
        .rdata (tr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            buf_reg     <= '0;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
            rd_idx_reg  <= '0;
            em_reg      <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (push_go || pop_empty || flush_go) begin
                        m_frame_reg     <= '0;
                        m_time_reg      <= '0;
                        m_last_reg      <= 1'b0;
                        m_ready_res_reg <= push_go && push_ready;
                        m_dropped_reg   <= push_drop;
                        if (push_go) begin
                            m_kind_reg <= cffdo_pkg::KIND_PUSH;
                        end else if (pop_empty) begin
                            m_kind_reg <= cffdo_pkg::KIND_EMPTY;
                        end else begin
                            m_kind_reg <= cffdo_pkg::KIND_FLUSH;
                        end
                    end
                    if (pop_go) begin
                        state_reg     <= ST_POP;
                        slot_reg      <= head_reg;
                        n_reg         <= pop_n;
                        pop_ready_reg <= pop_ready;
                        rd_idx_reg    <= '0;
                        em_reg        <= '0;
                        rd_pend_reg   <= 1'b0;
                    end
                end
                ST_POP: begin
                    if (f_issue) begin
                        rd_idx_reg  <= rd_idx_reg + LEN_W'(1);
                        rd_pend_reg <= 1'b1;
                    end else if (f_load) begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (f_load) begin
                        m_frame_reg     <= DATA_W'(64'(fr_data));
                        m_time_reg      <= $signed(tr_data);
                        m_kind_reg      <= cffdo_pkg::KIND_CHUNK;
                        m_last_reg      <= (em_reg + LEN_W'(1)) == n_reg;
                        m_ready_res_reg <= pop_ready_reg;
                        m_dropped_reg   <= 1'b0;
                        em_reg          <= em_reg + LEN_W'(1);
                        if ((em_reg + LEN_W'(1)) == n_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_frame        = m_frame_reg;
    assign m_chunk_start_time = m_time_reg;
    assign m_kind             = m_kind_reg;
    assign m_last             = m_last_reg;
    assign m_ready_res        = m_ready_res_reg;
    assign m_dropped          = m_dropped_reg;

endmodule

// ===== bench/chunked_frame_fifo_drop_oldest_unit_tb.sv =====
// ============================================================================
// Chunked frame FIFO testbench
// Drives push, pop and flush words into the chunked frame FIFO, with random
// gaps on both channels, one long stall on the result side and register
// writes between phases. A scoreboard keeps its own copy of the chunk buffer,
// predicts every result word and compares the output field by field.
// ============================================================================
module chunked_frame_fifo_drop_oldest_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_CHUNKS = cffdo_pkg::MAX_CHUNKS_DEF;
    localparam int CHUNK_SLOTS  = cffdo_pkg::MAX_CHUNK_FRAMES_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;
    localparam logic [cffdo_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [cffdo_pkg::DATA_W-1:0]        frame;
        logic signed [cffdo_pkg::TIME_W-1:0] start;
        cffdo_pkg::kind_t                    kind;
        logic                                last;
        logic                                ready_res;
        logic                                dropped;
    } chunk_result_t;

    class chunk_scoreboard;
        logic [cffdo_pkg::DATA_W-1:0] frame_mem [STORE_CHUNKS * CHUNK_SLOTS];
        bit                           frame_written [STORE_CHUNKS * CHUNK_SLOTS];
        logic [cffdo_pkg::TIME_W-1:0] start_time [STORE_CHUNKS];
        int unsigned                  head, tail, n_chunks, n_buffered, fill;
        logic [cffdo_pkg::LEN_W-1:0]  length_reg;
        logic [cffdo_pkg::LIM_W-1:0]  limit_reg;
        chunk_result_t                owed_words [$];
        int errors, n_pushes, n_drops, n_chunk_pops, n_frames_out, n_empty, n_flushes;

        function new();
            length_reg = cffdo_pkg::LEN_RESET;
            limit_reg  = cffdo_pkg::LIM_RESET;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        function int unsigned eff_len();
            if (length_reg == 0) return 1;
            if (length_reg > CHUNK_SLOTS) return CHUNK_SLOTS;
            return length_reg;
        endfunction

        function int unsigned eff_lim();
            if (limit_reg == 0 || limit_reg > STORE_CHUNKS) return STORE_CHUNKS;
            return limit_reg;
        endfunction

        function void write_reg(cffdo_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                cffdo_pkg::REG_CHUNK_LENGTH: length_reg = value[cffdo_pkg::LEN_W-1:0];
                cffdo_pkg::REG_CHUNK_LIMIT:  limit_reg  = value[cffdo_pkg::LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // A pop may only touch frame entries that some push has written.
        function bit pop_reads_written();
            int unsigned n;
            if (n_buffered == 0 || n_chunks == 0) return 1;
            n = (n_buffered < eff_len()) ? n_buffered : eff_len();
            for (int i = 0; i < n; i++)
                if (!frame_written[head * CHUNK_SLOTS + i]) return 0;
            return 1;
        endfunction

        function void queue_result(logic [cffdo_pkg::DATA_W-1:0] f,
                                   logic [cffdo_pkg::TIME_W-1:0] t,
                                   cffdo_pkg::kind_t k, bit l, bit r, bit d);
            chunk_result_t item;
            item = '{f, t, k, l, r, d};
            owed_words = {owed_words, item};
        endfunction

        function void store_frame(int unsigned addr, logic [cffdo_pkg::DATA_W-1:0] data);
            frame_mem[addr]     = data;
            frame_written[addr] = 1'b1;
        endfunction

        function void apply_word(logic [cffdo_pkg::OP_W-1:0] op,
                                 logic [cffdo_pkg::DATA_W-1:0] data,
                                 logic [cffdo_pkg::TIME_W-1:0] stamp);
            int unsigned len, slot, n;
            bit drop;
            len  = eff_len();
            drop = 1'b0;
            case (op)
                cffdo_pkg::OP_PUSH: begin
                    n_pushes++;
                    if (n_chunks > 0 && fill != 0 && fill < len) begin
                        slot = (tail + STORE_CHUNKS - 1) % STORE_CHUNKS;
                        store_frame(slot * CHUNK_SLOTS + fill, data);
                        fill++;
                        n_buffered++;
                        if (fill >= len) fill = 0;
                    end else begin
                        if (n_chunks + 1 > eff_lim()) begin
                            head = (head + 1) % STORE_CHUNKS;
                            n_chunks--;
                            n_buffered = (n_buffered > len) ? n_buffered - len : 0;
                            drop = 1'b1;
                            n_drops++;
                        end
                        store_frame(tail * CHUNK_SLOTS, data);
                        start_time[tail] = stamp;
                        tail = (tail + 1) % STORE_CHUNKS;
                        n_chunks++;
                        n_buffered++;
                        fill = (len > 1) ? 1 : 0;
                    end
                    queue_result('0, '0, cffdo_pkg::KIND_PUSH, 1'b0, n_buffered >= len, drop);
                end
                cffdo_pkg::OP_POP: begin
                    if (n_buffered == 0 || n_chunks == 0) begin
                        n_empty++;
                        queue_result('0, '0, cffdo_pkg::KIND_EMPTY, 1'b0, 1'b0, 1'b0);
                    end else begin
                        n_chunk_pops++;
                        n = (n_buffered < len) ? n_buffered : len;
                        slot = head;
                        head = (head + 1) % STORE_CHUNKS;
                        n_chunks--;
                        n_buffered -= n;
                        if (n_chunks == 0) begin
                            n_buffered = 0;
                            fill = 0;
                        end
                        for (int i = 0; i < n; i++) begin
                            n_frames_out++;
                            queue_result(frame_mem[slot * CHUNK_SLOTS + i], start_time[slot],
                                         cffdo_pkg::KIND_CHUNK, i + 1 == n,
                                         n_buffered >= len, 1'b0);
                        end
                    end
                end
                cffdo_pkg::OP_FLUSH: begin
                    n_flushes++;
                    head = 0;
                    tail = 0;
                    n_chunks = 0;
                    n_buffered = 0;
                    fill = 0;
                    queue_result('0, '0, cffdo_pkg::KIND_FLUSH, 1'b0, 1'b0, 1'b0);
                end
                default: ;
            endcase
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task match_output(chunk_result_t got);
            chunk_result_t want;
            if (owed_words.size() == 0) begin
                report($sformatf("unexpected result word, kind %0d", got.kind));
                return;
            end
            want = owed_words[0];
            owed_words.delete(0);
            compare_field("out_frame", 64'(got.frame), 64'(want.frame));
            compare_field("chunk_start_time", got.start, want.start);
            compare_field("kind", 64'(got.kind), 64'(want.kind));
            compare_field("last", 64'(got.last), 64'(want.last));
            compare_field("ready_res", 64'(got.ready_res), 64'(want.ready_res));
            compare_field("dropped", 64'(got.dropped), 64'(want.dropped));
        endtask

        task finish_check();
            if (owed_words.size() != 0)
                report($sformatf("%0d result words never arrived", owed_words.size()));
        endtask
    endclass

    logic                                aclk;
    logic                                aresetn = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [cffdo_pkg::APB_AW-1:0]        paddr = '0;
    logic [cffdo_pkg::APB_DW-1:0]        pwdata = '0;
    logic [cffdo_pkg::APB_DW-1:0]        prdata;
    logic                                pready;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [cffdo_pkg::OP_W-1:0]          s_operation = '0;
    logic [cffdo_pkg::DATA_W-1:0]        s_frame_data = '0;
    logic signed [cffdo_pkg::TIME_W-1:0] s_frame_time = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [cffdo_pkg::DATA_W-1:0]        m_out_frame;
    logic signed [cffdo_pkg::TIME_W-1:0] m_chunk_start_time;
    logic [cffdo_pkg::KIND_W-1:0]        m_kind;
    logic                                m_last;
    logic                                m_ready_res;
    logic                                m_dropped;

    chunk_scoreboard sb = new();
    int  idle_pct = 22;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;

    chunked_frame_fifo_drop_oldest_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_frame_data       (s_frame_data),
        .s_frame_time       (s_frame_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_frame        (m_out_frame),
        .m_chunk_start_time (m_chunk_start_time),
        .m_kind             (m_kind),
        .m_last             (m_last),
        .m_ready_res        (m_ready_res),
        .m_dropped          (m_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles.", cycle_count);
        $display("chunked_frame_fifo_drop_oldest_unit test failed");
        $finish;
    end

    // The result side stalls at random, and once for a long stretch on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.match_output('{m_out_frame, m_chunk_start_time,
                              cffdo_pkg::kind_t'(m_kind),
                              m_last, m_ready_res, m_dropped});
    end

    task automatic apb_write(cffdo_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic offer_word(logic [cffdo_pkg::OP_W-1:0] op,
                              logic [cffdo_pkg::DATA_W-1:0] data,
                              logic [cffdo_pkg::TIME_W-1:0] stamp);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_frame_data <= data;
        s_frame_time <= stamp;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        sb.apply_word(op, data, stamp);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_phase(logic [31:0] len, logic [31:0] lim, int count, int push_pct,
                             int idle, bit stall);
        int sent;
        int roll;
        sent = 0;
        drain();
        apb_write(cffdo_pkg::REG_CHUNK_LENGTH, len);
        apb_write(cffdo_pkg::REG_CHUNK_LIMIT, lim);
        idle_pct = idle;
        if (stall) hold_req = 1'b1;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
                offer_word(cffdo_pkg::OP_PUSH, $urandom, {$urandom, $urandom});
                sent++;
            end else if (roll < push_pct + 18) begin
                offer_word(sb.pop_reads_written() ? cffdo_pkg::OP_POP : cffdo_pkg::OP_FLUSH,
                           $urandom, {$urandom, $urandom});
                sent++;
            end else if (roll < 97) begin
                offer_word(cffdo_pkg::OP_FLUSH, $urandom, {$urandom, $urandom});
                sent++;
            end else begin
                offer_word(OP_IGNORED, $urandom, {$urandom, $urandom});
            end
        end
        idle_pct = 22;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: empty pops, an ignored word, extremes, a lone partial chunk.
        offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);
        offer_word(OP_IGNORED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(cffdo_pkg::OP_FLUSH, 32'h0, 64'h0);
        offer_word(cffdo_pkg::OP_PUSH, 32'h0000_0000, 64'h8000_0000_0000_0000);
        offer_word(cffdo_pkg::OP_PUSH, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(cffdo_pkg::OP_PUSH, 32'hA5A5_5A5A, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);
        offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);
        offer_word(cffdo_pkg::OP_PUSH, 32'h0000_0001, 64'h0);
        offer_word(cffdo_pkg::OP_FLUSH, 32'h0, 64'h0);
        offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);

        // Two-frame chunks with a limit of one chunk force drops.
        drain();
        apb_write(cffdo_pkg::REG_CHUNK_LENGTH, 32'd2);
        apb_write(cffdo_pkg::REG_CHUNK_LIMIT, 32'd1);
        for (int i = 0; i < 5; i++) offer_word(cffdo_pkg::OP_PUSH, $urandom, 64'(100 + i));
        offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);
        for (int i = 0; i < 3; i++) offer_word(cffdo_pkg::OP_PUSH, $urandom, 64'(200 + i));

        // Length zero and a limit above capacity, applied with frames still held.
        drain();
        apb_write(cffdo_pkg::REG_CHUNK_LENGTH, 32'd0);
        apb_write(cffdo_pkg::REG_CHUNK_LIMIT, 32'd31);
        offer_word(cffdo_pkg::OP_PUSH, 32'h5A5A_A5A5, 64'h1234_5678_9ABC_DEF0);
        offer_word(cffdo_pkg::OP_PUSH, 32'h8000_0001, 64'hEDCB_A987_6543_2110);
        for (int i = 0; i < 3; i++) offer_word(cffdo_pkg::OP_POP, 32'h0, 64'h0);

        run_phase(32'd4, 32'd3, 26, 75, 22, 1'b0);
        run_phase(32'd4, 32'd0, 26, 90, 22, 1'b0);
        run_phase(32'd4, 32'd2, 22, 70, 22, 1'b0);
        run_phase(32'd1, 32'd5, 20, 70, 22, 1'b0);
        run_phase(32'd127, 32'd17, 26, 90, 22, 1'b1);
        run_phase(32'd64, 32'd16, 26, 75, 0, 1'b0);
        run_phase(32'd8, 32'd1, 20, 75, 22, 1'b0);
        run_phase(32'd3, 32'd31, 20, 65, 22, 1'b0);

        drain();
        $display("Run covered %0d pushes (%0d dropped an old chunk),", sb.n_pushes, sb.n_drops);
        $display("%0d chunk pops with %0d frames, %0d empty pops and %0d flushes.",
                 sb.n_chunk_pops, sb.n_frames_out, sb.n_empty, sb.n_flushes);
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("chunked_frame_fifo_drop_oldest_unit test passed");
        end else begin
            $display("%0d mismatches found.", sb.errors);
            $display("chunked_frame_fifo_drop_oldest_unit test failed");
        end
        $finish;
    end

endmodule
